// ===== rtl/tacho_period_to_rpm_filter_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef TACHO_PERIOD_TO_RPM_FILTER_UNIT_DEFINES_SVH
`define TACHO_PERIOD_TO_RPM_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define TPRF_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define TPRF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/tprf_pkg.sv =====
`default_nettype none

package tprf_pkg;

  localparam int unsigned DATA_W            = 16;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned NUM_W = 26;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] RPM_NUMERATOR = 26'd60000000;

  localparam int unsigned GAIN_CNT_W = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] GAIN_RESET       = 16'd21234;
  localparam logic [DATA_W-1:0] MIN_PERIOD_RESET = 16'd4000;
  localparam logic [DATA_W-1:0] MAX_PERIOD_RESET = 16'd65000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_GAIN = 2'd0,
    REG_MIN_PERIOD  = 2'd1,
    REG_MAX_PERIOD  = 2'd2
  } tprf_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH,
    ST_DONE
  } tprf_state_e;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] raw;
  } tprf_raw_req_t;

endpackage

`default_nettype wire

// ===== rtl/tprf_divider.sv =====
`default_nettype none

module tprf_divider import tprf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DATA_W-1:0] period_i,
  output tprf_raw_req_t          out_o,
  input  wire logic              out_ready_i
);

  tprf_state_e            state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0]      rem_q;
  logic [NUM_W-1:0]       quo_q;
  logic [DATA_W-1:0]      div_q;
  logic                   start;
  logic                   step;
  logic [DATA_W:0]        trial;
  logic [DATA_W:0]        trial_sub;
  logic                   fits;

  // one quotient bit per cycle, msb first
  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign fits      = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    start   = 1'b0;
    step    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start   = 1'b1;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step  = 1'b1;
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= RPM_NUMERATOR;
      div_q <= period_i;
    end else if (step) begin
      rem_q <= fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_o.valid = (state_q == ST_DONE);
  // saturate when the quotient needs more than 16 bits
  assign out_o.raw   = (|quo_q[NUM_W-1:DATA_W]) ? '1 : quo_q[DATA_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/tprf_filter.sv =====
`default_nettype none

module tprf_filter import tprf_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tprf_raw_req_t     in_i,
  output logic                   in_ready_o,
  input  wire logic [DATA_W-1:0] gain_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DATA_W-1:0]      raw_speed_o,
  output logic [DATA_W-1:0]      filtered_speed_o
);

  localparam int unsigned ACC_W  = DATA_W + FRACTION_BITS;
  localparam int unsigned DIFF_W = ACC_W + 1;
  localparam int unsigned HI_W   = DIFF_W + 1;

  tprf_state_e             state_q, state_d;
  logic [GAIN_CNT_W-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0]        acc_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [DATA_W-1:0]       gain_q;
  logic signed [HI_W-1:0]  hi_q;
  logic [DATA_W-1:0]       raw_q;
  logic [DATA_W-1:0]       raw_speed_q;
  logic [DATA_W-1:0]       filt_q;
  logic                    load;
  logic                    step;
  logic                    finish;
  logic [ACC_W-1:0]        target;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [HI_W-1:0]  addend;
  logic signed [HI_W-1:0]  sum;
  logic signed [HI_W-1:0]  acc_sum;
  logic [ACC_W-1:0]        acc_next;

  assign target = ACC_W'(in_i.raw) << FRACTION_BITS;
  assign diff_w = $signed({1'b0, target}) - $signed({1'b0, acc_q});

  // lsb-first shift-add; the arithmetic shift floors each step
  assign addend = gain_q[0] ? {diff_q[DIFF_W-1], diff_q} : '0;
  assign sum    = hi_q + addend;

  assign acc_sum  = $signed({2'b00, acc_q}) + hi_q;
  assign acc_next = acc_sum[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (finish) begin
        acc_q <= acc_next;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    load    = 1'b0;
    step    = 1'b0;
    finish  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step  = 1'b1;
        cnt_d = cnt_q + GAIN_CNT_W'(1);
        if (cnt_q == GAIN_CNT_W'(DATA_W - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish  = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      diff_q <= diff_w;
      gain_q <= gain_i;
      hi_q   <= '0;
      raw_q  <= in_i.raw;
    end else if (step) begin
      hi_q   <= sum >>> 1;
      gain_q <= gain_q >> 1;
    end
    if (finish) begin
      raw_speed_q <= raw_q;
      filt_q      <= acc_next[FRACTION_BITS +: DATA_W];
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = (state_q == ST_DONE);
  assign raw_speed_o      = raw_speed_q;
  assign filtered_speed_o = filt_q;

endmodule

`default_nettype wire

// ===== rtl/tacho_period_to_rpm_filter_unit.sv =====
// path: an accepted request passes the 26-step divider, a handoff into the filter,
//   the 16-step serial gain multiply and an accumulate step before m_axis_tvalid_o
// overlap: the bit-serial divider takes a new request only once its last result is
//   handed on; the filter runs on one item while the divider works on the next
// reset: registers return to gain 21234, periods 4000 and 65000, accumulator zero
`default_nettype none

module tacho_period_to_rpm_filter_unit import tprf_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [DATA_W-1:0]    s_axis_tdata_i,   // [15:0] pulse_period
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [2*DATA_W-1:0]       m_axis_tdata_o,   // [15:0] raw_speed, [31:16] filtered_speed
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  logic [DATA_W-1:0] gain_q;
  logic [DATA_W-1:0] min_period_q;
  logic [DATA_W-1:0] max_period_q;
  logic [DATA_W-1:0] period_clamped;
  tprf_raw_req_t     raw_req;
  logic              raw_ready;
  logic [DATA_W-1:0] raw_speed;
  logic [DATA_W-1:0] filtered_speed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= GAIN_RESET;
      min_period_q <= MIN_PERIOD_RESET;
      max_period_q <= MAX_PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FILTER_GAIN: gain_q       <= cfg_data_i;
        REG_MIN_PERIOD:  min_period_q <= cfg_data_i;
        REG_MAX_PERIOD:  max_period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // upper clamp wins when the limits cross
  always_comb begin
    period_clamped = s_axis_tdata_i;
    if (s_axis_tdata_i > max_period_q) begin
      period_clamped = max_period_q;
    end else if (s_axis_tdata_i < min_period_q) begin
      period_clamped = min_period_q;
    end
  end

  tprf_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .period_i    (period_clamped),
    .out_o       (raw_req),
    .out_ready_i (raw_ready)
  );

  tprf_filter #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (raw_req),
    .in_ready_o       (raw_ready),
    .gain_i           (gain_q),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .raw_speed_o      (raw_speed),
    .filtered_speed_o (filtered_speed)
  );

  assign m_axis_tdata_o = {filtered_speed, raw_speed};

endmodule

`default_nettype wire

// ===== rtl/tprf_checker.sv =====
`default_nettype none
`include "tacho_period_to_rpm_filter_unit_defines.svh"

module tprf_checker import tprf_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic [DATA_W-1:0]    s_axis_tdata_i,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [2*DATA_W-1:0]  m_axis_tdata_o,
  input wire logic                 cfg_we_i,
  input wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [DATA_W-1:0]    cfg_data_i
);

  logic s_take;
  logic m_take;
  logic m_stall;
  logic unused_ok;

  assign s_take    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_take    = m_axis_tvalid_o && m_axis_tready_i;
  assign m_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign unused_ok = ^{s_axis_tdata_i, cfg_we_i, cfg_index_i, cfg_data_i};

  `TPRF_ASSERT_NEXT(a_out_valid_holds, m_stall, m_axis_tvalid_o, "output request dropped")
  `TPRF_ASSERT_NEXT(a_out_data_holds, m_stall, $stable(m_axis_tdata_o), "output data changed")
  `TPRF_ASSERT_NEXT(a_busy_after_take, s_take, !s_axis_tready_o, "divider took two requests")
  `TPRF_ASSERT_NEXT(a_gap_after_out, m_take, !m_axis_tvalid_o, "result repeated after take")
  `TPRF_ASSERT_IMPL(a_raw_floor, m_axis_tvalid_o || unused_ok,
                    !m_axis_tvalid_o || (m_axis_tdata_o[DATA_W-1:0] >= 16'd915),
                    "raw speed below the slowest period")

endmodule

bind tacho_period_to_rpm_filter_unit tprf_checker u_tprf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i),
  .cfg_data_i      (cfg_data_i)
);

`default_nettype wire
